FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the sharpen filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SH3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SH3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sh3_pkg.sv
// Shared widths, register codes and structs of the 3x3 sharpen filter.
package sh3_pkg;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 16;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 13;
    localparam int SPAN_W     = 14;
    localparam int SUM_W      = 13;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [COL_W-1:0] COLUMNS_RESET  = 12'd640;
    localparam logic [ROW_W-1:0] ROWS_RESET     = 16'd480;
    localparam logic [CH_W-1:0]  CHANNELS_RESET = 3'd1;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_COLUMNS  = 2'd0,
        REG_ROWS     = 2'd1,
        REG_CHANNELS = 2'd2
    } reg_index_t;

    // Clamped frame geometry derived from the registers
    typedef struct packed {
        logic [COL_W-1:0]  cols;
        logic [ROW_W-1:0]  rows;
        logic [CH_W-1:0]   ch;
        logic [SPAN_W-1:0] span;
        logic [SPAN_W-1:0] right_start;
    } geom_t;

    // Where the current sample sits in the frame
    typedef struct packed {
        logic has_result;
        logic border;
        logic last_row;
    } pos_info_t;

endpackage

FILE: hw/rtl/sh3_cfg.sv
// APB register file and geometry clamping of the sharpen filter.
module sh3_cfg #(
    parameter int MAX_COLUMNS  = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sh3_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sh3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sh3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output sh3_pkg::geom_t                     geom
);
    import sh3_pkg::*;

    logic [COL_W-1:0] columns_reg;
    logic [ROW_W-1:0] rows_reg;
    logic [CH_W-1:0]  channels_reg;
    logic             wr_en;
    reg_index_t       reg_idx;
    logic [COL_W-1:0] cols;
    logic [ROW_W-1:0] rows;
    logic [CH_W-1:0]  ch;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_index_t'(paddr[3:2]);

    // Write registers on the access phase of a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg  <= COLUMNS_RESET;
            rows_reg     <= ROWS_RESET;
            channels_reg <= CHANNELS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COLUMNS:  columns_reg  <= pwdata[COL_W-1:0];
                REG_ROWS:     rows_reg     <= pwdata[ROW_W-1:0];
                REG_CHANNELS: channels_reg <= pwdata[CH_W-1:0];
                default:      ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        unique case (reg_idx)
            REG_COLUMNS:  prdata = APB_DATA_W'(columns_reg);
            REG_ROWS:     prdata = APB_DATA_W'(rows_reg);
            REG_CHANNELS: prdata = APB_DATA_W'(channels_reg);
            default:      prdata = '0;
        endcase
    end

    // Clamp the geometry to the supported range
    always_comb
    begin
        if (columns_reg < COL_W'(3))
            cols = COL_W'(3);
        else if (32'(columns_reg) > 32'(MAX_COLUMNS))
            cols = COL_W'(MAX_COLUMNS);
        else
            cols = columns_reg;

        if (rows_reg < ROW_W'(3))
            rows = ROW_W'(3);
        else
            rows = rows_reg;

        if (channels_reg == '0)
            ch = CH_W'(1);
        else if (32'(channels_reg) > 32'(MAX_CHANNELS))
            ch = CH_W'(MAX_CHANNELS);
        else
            ch = channels_reg;
    end

    assign geom.cols        = cols;
    assign geom.rows        = rows;
    assign geom.ch          = ch;
    assign geom.span        = SPAN_W'(cols) * SPAN_W'(ch);
    assign geom.right_start = SPAN_W'(cols - COL_W'(1)) * SPAN_W'(ch);

endmodule

FILE: hw/rtl/sh3_pos.sv
// Row and sample counters with border and last-row decode.
module sh3_pos (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  sh3_pkg::geom_t                  geom,
    output logic [sh3_pkg::SAMPLE_W-1:0]    sample_idx,
    output sh3_pkg::pos_info_t              info
);
    import sh3_pkg::*;

    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] sample_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic                row_end;
    logic                last_row;

    assign last_row = row_reg >= (geom.rows - ROW_W'(1));
    assign row_end  = (SPAN_W'(sample_reg) + SPAN_W'(1)) >= geom.span;

    // Decode position of the incoming sample
    assign info.has_result = row_reg != '0;
    assign info.last_row   = last_row;
    assign info.border     = (row_reg == ROW_W'(1))
                          || ({1'b0, sample_reg} < SPAN_W'(geom.ch))
                          || ({1'b0, sample_reg} >= geom.right_start);
    assign sample_idx      = sample_reg;

    // Advance counters on each transfer, wrap at row and frame end
    always_comb
    begin
        sample_next = sample_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                sample_next = '0;
                row_next    = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                sample_next = sample_reg + SAMPLE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            row_reg    <= row_next;
        end
    end

endmodule

FILE: hw/rtl/sh3_line_buf.sv
// Two line stores with registered reads and a short left-neighbor history.
module sh3_line_buf #(
    parameter int MAX_COLUMNS  = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            has_result,
    input  logic [sh3_pkg::SAMPLE_W-1:0]    sample_idx,
    input  logic [sh3_pkg::CH_W-1:0]        ch,
    input  logic [sh3_pkg::PIX_W-1:0]       pixel,
    output logic [sh3_pkg::PIX_W-1:0]       centre,
    output logic [sh3_pkg::PIX_W-1:0]       right,
    output logic [sh3_pkg::PIX_W-1:0]       up,
    output logic [sh3_pkg::PIX_W-1:0]       left
);
    import sh3_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EXT_W = ((AW > SAMPLE_W) ? AW : SAMPLE_W) + 1;
    localparam int HW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [PIX_W-1:0] middle_mem [DEPTH];
    logic [PIX_W-1:0] upper_mem  [DEPTH];
    logic [PIX_W-1:0] hist_reg   [MAX_CHANNELS];

    logic [PIX_W-1:0] centre_reg;
    logic [PIX_W-1:0] right_reg;
    logic [PIX_W-1:0] up_reg;
    logic             move_pend_reg;
    logic [AW-1:0]    move_addr_reg;

    logic [EXT_W-1:0] idx_ext;
    logic [EXT_W-1:0] right_ext;
    logic [AW-1:0]    addr_s;
    logic [AW-1:0]    addr_r;
    logic             in_range;
    logic [CH_W-1:0]  ch_m1;

    assign idx_ext   = EXT_W'(sample_idx);
    assign right_ext = idx_ext + EXT_W'(ch);
    assign addr_s    = idx_ext[AW-1:0];
    assign addr_r    = right_ext[AW-1:0];
    assign in_range  = idx_ext < EXT_W'(DEPTH);
    assign ch_m1     = ch - CH_W'(1);

    // Read row r-1 at the sample and its right neighbor, store the new sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            centre_reg <= middle_mem[addr_s];
            right_reg  <= middle_mem[addr_r];
            if (in_range)
                middle_mem[addr_s] <= pixel;
        end
    end

    // Read row r-2; move the old middle entry up in the cycle after its read
    always_ff @(posedge clk)
    begin
        if (accept)
            up_reg <= upper_mem[addr_s];
        if (move_pend_reg)
            upper_mem[move_addr_reg] <= centre_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            move_pend_reg <= 1'b0;
        else
            move_pend_reg <= accept && has_result && in_range;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            move_addr_reg <= addr_s;
    end

    // Keep the last few centre reads: the left neighbor is one pixel back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg[0] <= centre_reg;
            for (int k = 1; k < MAX_CHANNELS; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

    assign centre = centre_reg;
    assign right  = right_reg;
    assign up     = up_reg;
    assign left   = hist_reg[ch_m1[HW-1:0]];

endmodule

FILE: hw/rtl/sh3_out.sv
// Kernel arithmetic, result sequencing and output register.
module sh3_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  sh3_pkg::pos_info_t          info,
    input  logic [sh3_pkg::PIX_W-1:0]   pixel,
    input  logic [sh3_pkg::PIX_W-1:0]   centre,
    input  logic [sh3_pkg::PIX_W-1:0]   right,
    input  logic [sh3_pkg::PIX_W-1:0]   up,
    input  logic [sh3_pkg::PIX_W-1:0]   left,
    input  logic                        result_stall,
    output logic                        result_valid,
    output logic [sh3_pkg::PIX_W-1:0]   filtered_sample,
    output logic                        last_of_item,
    output logic                        busy
);
    import sh3_pkg::*;

    // 5*centre minus the four neighbors, saturated to the pixel range
    function automatic logic [PIX_W-1:0] sharpen(
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] l,
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] u,
        input logic [PIX_W-1:0] d
    );
        logic [SUM_W-2:0]        five_c;
        logic [SUM_W-2:0]        neg;
        logic signed [SUM_W-1:0] acc;
        logic [PIX_W-1:0]        res;
        five_c = ({3'b0, c} << 2) + {3'b0, c};
        neg    = {3'b0, l} + {3'b0, r} + {3'b0, u} + {3'b0, d};
        acc    = $signed({1'b0, five_c}) - $signed({1'b0, neg});
        if (acc < 0)
            res = '0;
        else if (acc > 13'sd255)
            res = 8'hFF;
        else
            res = acc[PIX_W-1:0];
        return res;
    endfunction

    logic             s1_valid_reg;
    logic             s1_valid_next;
    pos_info_t        s1_info_reg;
    logic [PIX_W-1:0] s1_down_reg;
    logic             phase_reg;
    logic             phase_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] out_sample_reg;
    logic             out_last_reg;

    logic             out_load;
    logic             s1_emit;
    logic             s1_done;
    logic [PIX_W-1:0] kernel_val;
    logic [PIX_W-1:0] emit_sample;
    logic             emit_last;

    // Decide whether the held sample leaves the stage this cycle
    assign out_load = !out_valid_reg || !result_stall;
    assign s1_emit  = s1_valid_reg && s1_info_reg.has_result && out_load;
    assign s1_done  = s1_valid_reg && (!s1_info_reg.has_result
                   || (out_load && (!s1_info_reg.last_row || phase_reg)));
    assign busy     = s1_valid_reg && !s1_done;

    // Form the result: last row adds a zero border result after the first
    assign kernel_val  = s1_info_reg.border ? '0
                       : sharpen(centre, left, right, up, s1_down_reg);
    assign emit_sample = phase_reg ? '0 : kernel_val;
    assign emit_last   = phase_reg || !s1_info_reg.last_row;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        phase_next    = phase_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            phase_next    = 1'b0;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
            phase_next    = 1'b0;
        end
        else if (s1_emit)
        begin
            phase_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = s1_emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture stage payload on transfer, result payload on load
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
            s1_down_reg <= pixel;
        end
        if (s1_emit)
        begin
            out_sample_reg <= emit_sample;
            out_last_reg   <= emit_last;
        end
    end

    assign result_valid    = out_valid_reg;
    assign filtered_sample = out_sample_reg;
    assign last_of_item    = out_last_reg;

endmodule

FILE: hw/rtl/sharpen_3x3_stream.sv
// A sample is held in the stage register, then its result in the output register.
// Throughput: one sample per cycle without result stalls; in the last row each
// sample gives two results through the single output register, and the next waits.
// Reset clears the counters, the pipeline valids and the registers to 640x480x1.
// The line stores are not cleared; they hold no data until the first row fills them.
// Sharpen filter top level: register file, counters, line stores and output stage.
module sharpen_3x3_stream #(
    parameter int MAX_COLUMNS  = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sh3_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sh3_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sh3_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [sh3_pkg::PIX_W-1:0]       pixel_sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [sh3_pkg::PIX_W-1:0]       filtered_sample,
    output logic                            last_of_item
);
    import sh3_pkg::*;

    geom_t               geom;
    pos_info_t           info;
    logic [SAMPLE_W-1:0] sample_idx;
    logic                accept;
    logic                busy;
    logic [PIX_W-1:0]    centre;
    logic [PIX_W-1:0]    right;
    logic [PIX_W-1:0]    up;
    logic [PIX_W-1:0]    left;

    // Take a sample whenever the stage register is free
    assign sample_stall = busy;
    assign accept       = sample_valid && !sample_stall;

    sh3_cfg #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    sh3_pos u_pos (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .geom       (geom),
        .sample_idx (sample_idx),
        .info       (info)
    );

    sh3_line_buf #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_line_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .has_result (info.has_result),
        .sample_idx (sample_idx),
        .ch         (geom.ch),
        .pixel      (pixel_sample),
        .centre     (centre),
        .right      (right),
        .up         (up),
        .left       (left)
    );

    sh3_out u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .info            (info),
        .pixel           (pixel_sample),
        .centre          (centre),
        .right           (right),
        .up              (up),
        .left            (left),
        .result_stall    (result_stall),
        .result_valid    (result_valid),
        .filtered_sample (filtered_sample),
        .last_of_item    (last_of_item),
        .busy            (busy)
    );

endmodule

FILE: hw/rtl/sh3_checker.sv
// Port-level checks of the sharpen filter, bound to the top level.
`include "assert_macros.svh"

module sh3_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pready,
    input logic                        sample_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input logic [sh3_pkg::PIX_W-1:0]   filtered_sample,
    input logic                        last_of_item
);

    // Register port never inserts wait states
    `SH3_ASSERT_IMPLY(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")

    // A first result of a last-row sample is followed at once by its zero border
    `SH3_ASSERT_NEXT(a_border_follows, clk, rst_n, result_valid && !result_stall && !last_of_item, result_valid && last_of_item && (filtered_sample == '0), "missing border result")

    // Input back-pressure with an empty output register must load a result
    `SH3_ASSERT_NEXT(a_stall_loads, clk, rst_n, sample_stall && !result_valid, result_valid, "stall without pending result")

    // A stalled result holds
    `SH3_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(filtered_sample) && $stable(last_of_item), "stalled result changed")

endmodule

bind sharpen_3x3_stream sh3_checker u_sh3_checker (.*);

FILE: tb/sharpen_3x3_stream_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the streaming 3x3 sharpen filter with its own filter predictor.
module sharpen_3x3_stream_tb;
    import sh3_pkg::*;

    localparam int MAX_COLS      = 2048;
    localparam int MAX_CH        = 4;
    localparam int MAX_ROWS      = 65535;
    localparam int LINE_DEPTH    = MAX_COLS * MAX_CH;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] SPARE_INDEX = 2'd3;

    typedef enum int {
        PAT_UNIFORM,
        PAT_SMOOTH,
        PAT_EXTREME
    } pattern_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } result_t;

    typedef struct packed {
        logic             setup;
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] rows;
        logic [CH_W-1:0]  ch;
        logic [PIX_W-1:0] pixel;
        logic             typed;
        logic [1:0]       count;
        result_t          first;
        result_t          second;
    } plan_entry_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    logic [PIX_W-1:0]      pixel_sample = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [PIX_W-1:0]      filtered_sample;
    logic                  last_of_item;

    // Predictor copy of the registers, line stores and position counters
    logic [COL_W-1:0]    geo_cols = COLUMNS_RESET;
    logic [ROW_W-1:0]    geo_rows = ROWS_RESET;
    logic [CH_W-1:0]     geo_ch = CHANNELS_RESET;
    logic [PIX_W-1:0]    upper_line [LINE_DEPTH];
    logic [PIX_W-1:0]    middle_line [LINE_DEPTH];
    logic [ROW_W-1:0]    pred_row = '0;
    logic [SAMPLE_W-1:0] pred_pos = '0;

    result_t     sharpened_q [$];
    plan_entry_t plan [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          items_sent = 0;
    int          hold_at = -1;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    sharpen_3x3_stream dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .pixel_sample    (pixel_sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .filtered_sample (filtered_sample),
        .last_of_item    (last_of_item)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Sharpen one sample and advance the predictor; returns the number of results
    function automatic int sharpen_predict(input logic [PIX_W-1:0] x, output result_t first,
                                           output result_t second);
        int unsigned cols, rows, ch, width, s, r, col;
        int          centre, left, right, up, acc;
        bit          last_row;
        bit          border;
        cols = clamp_to(32'(geo_cols), 3, MAX_COLS);
        rows = clamp_to(32'(geo_rows), 3, MAX_ROWS);
        ch = clamp_to(32'(geo_ch), 1, MAX_CH);
        width = cols * ch;
        s = 32'(pred_pos);
        r = 32'(pred_row);
        last_row = (r >= rows - 1);
        first = '0;
        second = '0;
        sharpen_predict = 0;
        if (r >= 1)
        begin
            col = s / ch;
            border = (r == 1) || (col == 0) || (col >= cols - 1);
            if (!border)
            begin
                centre = int'(middle_line[s]);
                right = int'(middle_line[s + ch]);
                left = int'(upper_line[s - ch]);
                up = int'(upper_line[s]);
                acc = 5 * centre - left - right - up - int'(x);
                if (acc < 0)
                    first.value = '0;
                else if (acc > 255)
                    first.value = '1;
                else
                    first.value = acc[PIX_W-1:0];
            end
            first.last = !last_row;
            sharpen_predict = 1;
            // the last row also emits its zero border result
            if (last_row)
            begin
                second.last = 1'b1;
                sharpen_predict = 2;
            end
        end
        // Shift the line stores at this position
        if (s < LINE_DEPTH)
        begin
            if (r >= 1)
                upper_line[s] = middle_line[s];
            middle_line[s] = x;
        end
        // Advance the position, wrap at row and frame end
        if (s + 1 >= width)
        begin
            pred_pos = '0;
            pred_row = last_row ? '0 : ROW_W'(r + 1);
        end
        else
            pred_pos = SAMPLE_W'(s + 1);
    endfunction

    function automatic plan_entry_t geometry(input int unsigned c, input int unsigned r,
                                             input int unsigned k);
        geometry = '0;
        geometry.setup = 1'b1;
        geometry.cols = COL_W'(c);
        geometry.rows = ROW_W'(r);
        geometry.ch = CH_W'(k);
    endfunction

    function automatic plan_entry_t sample_row(input logic [PIX_W-1:0] pix, input bit typed,
                                               input int n, input logic [PIX_W-1:0] v);
        sample_row = '0;
        sample_row.pixel = pix;
        sample_row.typed = typed;
        sample_row.count = 2'(n);
        sample_row.first.value = v;
        sample_row.first.last = (n == 1);
        sample_row.second.last = (n == 2);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input pattern_t pattern,
                                                    input logic [PIX_W-1:0] base);
        case (pattern)
            PAT_SMOOTH:  pick_pixel = base + PIX_W'($urandom_range(15));
            PAT_EXTREME: pick_pixel = $urandom_range(1) ? '1 : '0;
            default:     pick_pixel = PIX_W'($urandom_range(255));
        endcase
    endfunction

    // One register transfer: setup cycle, access cycle, then release the bus
    task automatic apb_access(input logic [1:0] index, input bit is_write,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] read_data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        read_data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] unused;
        apb_access(index, 1'b1, data, unused);
        case (index)
            REG_COLUMNS:  geo_cols = data[COL_W-1:0];
            REG_ROWS:     geo_rows = data[ROW_W-1:0];
            REG_CHANNELS: geo_ch = data[CH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_register(input logic [1:0] index, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_access(index, 1'b0, '0, got);
        if (got !== want)
            flag_mismatch($sformatf("register %0d read %0h, want %0h", index, got, want));
    endtask

    // Drop valid and wait until the block has gone quiet
    task automatic settle_block();
        sample_valid <= 1'b0;
        while (sharpened_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_geometry(input logic [APB_DATA_W-1:0] c, input logic [APB_DATA_W-1:0] r,
                                input logic [APB_DATA_W-1:0] k);
        settle_block();
        apb_write(REG_COLUMNS, c);
        apb_write(REG_ROWS, r);
        apb_write(REG_CHANNELS, k);
    endtask

    // Offer one sample, hold it until the transfer, then queue what it causes
    task automatic send_sample(input logic [PIX_W-1:0] x, input bit typed, input int n_typed,
                               input result_t t0, input result_t t1);
        result_t p0, p1;
        int      n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        pixel_sample <= x;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        n = sharpen_predict(x, p0, p1);
        if (typed)
        begin
            if (n_typed > 0)
                sharpened_q.push_back(t0);
            if (n_typed > 1)
                sharpened_q.push_back(t1);
        end
        else
        begin
            if (n > 0)
                sharpened_q.push_back(p0);
            if (n > 1)
                sharpened_q.push_back(p1);
        end
        @(negedge clk);
    endtask

    // Send one whole frame of the current geometry with one pixel pattern
    task automatic send_frame();
        int unsigned      total;
        pattern_t         pattern;
        logic [PIX_W-1:0] base;
        total = clamp_to(32'(geo_cols), 3, MAX_COLS) * clamp_to(32'(geo_rows), 3, MAX_ROWS)
              * clamp_to(32'(geo_ch), 1, MAX_CH);
        pattern = pattern_t'($urandom_range(2));
        base = PIX_W'($urandom_range(240));
        repeat (total)
        begin
            send_sample(pick_pixel(pattern, base), 1'b0, 0, '0, '0);
            items_sent++;
        end
    endtask

    // Whole frames of small random geometry, now and then with clamped register values
    task automatic run_random_frames(input int quota);
        int          start;
        int unsigned c, r, k;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            if ($urandom_range(7) == 0)
            begin
                c = $urandom_range(2);
                r = $urandom_range(2);
                k = $urandom_range(1) ? 0 : $urandom_range(7, 5);
            end
            else
            begin
                c = $urandom_range(12, 3);
                r = $urandom_range(6, 3);
                k = $urandom_range(MAX_CH, 1);
            end
            set_geometry(c, r, k);
            send_frame();
        end
    endtask

    // Stall the result side at random, or for a long stretch once the hold point is reached
    always @(negedge clk)
    begin
        if (!hold_done && items_sent == hold_at)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (sharpened_q.size() == 0)
                flag_mismatch($sformatf("unexpected result %0d last %0b",
                                        filtered_sample, last_of_item));
            else
            begin
                want = sharpened_q.pop_front();
                if (filtered_sample !== want.value)
                    flag_mismatch($sformatf("filtered_sample %0d, want %0d",
                                            filtered_sample, want.value));
                if (last_of_item !== want.last)
                    flag_mismatch($sformatf("last_of_item %0b, want %0b",
                                            last_of_item, want.last));
            end
        end
    end

    // End the run if it hangs
    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("sharpen_3x3_stream regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        plan_entry_t st;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers after reset, then every bit set, with a write past the register list
        check_register(REG_COLUMNS, APB_DATA_W'(COLUMNS_RESET));
        check_register(REG_ROWS, APB_DATA_W'(ROWS_RESET));
        check_register(REG_CHANNELS, APB_DATA_W'(CHANNELS_RESET));
        apb_write(REG_COLUMNS, '1);
        apb_write(REG_ROWS, '1);
        apb_write(REG_CHANNELS, '1);
        apb_write(SPARE_INDEX, '0);
        check_register(REG_COLUMNS, APB_DATA_W'({COL_W{1'b1}}));
        check_register(REG_ROWS, APB_DATA_W'({ROW_W{1'b1}}));
        check_register(REG_CHANNELS, APB_DATA_W'({CH_W{1'b1}}));

        // Clamped 3x3 grey frame: a lone bright centre saturates high
        plan.push_back(geometry(2, 0, 0));
        plan.push_back(sample_row(8'd0, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd255, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 2, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 2, 8'd255));
        plan.push_back(sample_row(8'd0, 1'b1, 2, 8'd0));
        // 4x3 grey frame: a dark centre saturates low, the next one lands mid range
        plan.push_back(geometry(4, 3, 1));
        plan.push_back(sample_row(8'd10, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd255, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd200, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd30, 1'b1, 0, 8'd0));
        plan.push_back(sample_row(8'd255, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd0, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd100, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd40, 1'b1, 1, 8'd0));
        plan.push_back(sample_row(8'd5, 1'b1, 2, 8'd0));
        plan.push_back(sample_row(8'd255, 1'b1, 2, 8'd0));
        plan.push_back(sample_row(8'd77, 1'b0, 0, 8'd0));
        plan.push_back(sample_row(8'd99, 1'b1, 2, 8'd0));

        // Walk the directed plan
        send_idle_pct = 11;
        recv_idle_pct = 48;
        foreach (plan[i])
        begin
            st = plan[i];
            if (st.setup)
                set_geometry(APB_DATA_W'(st.cols), APB_DATA_W'(st.rows), APB_DATA_W'(st.ch));
            else
                send_sample(st.pixel, st.typed, st.count, st.first, st.second);
        end

        // Sender idles rarely, receiver often, with one long hold-off
        hold_at = 150;
        run_random_frames(620);

        // Sender idles often, receiver rarely
        hold_at = -1;
        send_idle_pct = 48;
        recv_idle_pct = 11;
        run_random_frames(620);

        // No idling: one wide frame with clamped rows and channels, then small frames
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_geometry(48, 2, 7);
        send_frame();
        run_random_frames(40);

        settle_block();
        if (mismatch_count == 0 && sharpened_q.size() == 0)
            $display("sharpen_3x3_stream regression: pass");
        else
            $display("sharpen_3x3_stream regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sh3_pkg.sv
hw/rtl/sh3_cfg.sv
hw/rtl/sh3_pos.sv
hw/rtl/sh3_line_buf.sv
hw/rtl/sh3_out.sv
hw/rtl/sharpen_3x3_stream.sv
hw/rtl/sh3_checker.sv
tb/sharpen_3x3_stream_tb.sv
